// File: hw/rtl/script_token_scanner_defines.svh
// ----------------------------------------------------------------------------
// script token scanner assertion macros
// shared assertion forms for the scanner rtl
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_DEFINES_SVH

// implication checked on every edge outside reset
`define STS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, kind codes and helpers for the script token scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 16;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 6;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_COMMENT = 4'd2,
        M_BANG    = 4'd3,
        M_EQUAL   = 4'd4,
        M_LESS    = 4'd5,
        M_GREATER = 4'd6,
        M_IDENT   = 4'd7,
        M_NUM     = 4'd8,
        M_NUMDOT  = 4'd9,
        M_FRAC    = 4'd10,
        M_STRING  = 4'd11,
        M_DONE    = 4'd12
    } mode_t;

    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd4;
    localparam logic [KIND_BITS-1:0] K_DOT      = 6'd5;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd6;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd7;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd9;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd10;
    localparam logic [KIND_BITS-1:0] K_BANG     = 6'd11;
    localparam logic [KIND_BITS-1:0] K_BANG_EQ  = 6'd12;
    localparam logic [KIND_BITS-1:0] K_EQUAL    = 6'd13;
    localparam logic [KIND_BITS-1:0] K_EQ_EQ    = 6'd14;
    localparam logic [KIND_BITS-1:0] K_GREATER  = 6'd15;
    localparam logic [KIND_BITS-1:0] K_GT_EQ    = 6'd16;
    localparam logic [KIND_BITS-1:0] K_LESS     = 6'd17;
    localparam logic [KIND_BITS-1:0] K_LT_EQ    = 6'd18;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd19;
    localparam logic [KIND_BITS-1:0] K_STRING   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd21;
    localparam logic [KIND_BITS-1:0] K_AND      = 6'd22;
    localparam logic [KIND_BITS-1:0] K_ELSE     = 6'd23;
    localparam logic [KIND_BITS-1:0] K_FALSE    = 6'd24;
    localparam logic [KIND_BITS-1:0] K_FOR      = 6'd25;
    localparam logic [KIND_BITS-1:0] K_FUN      = 6'd26;
    localparam logic [KIND_BITS-1:0] K_IF       = 6'd27;
    localparam logic [KIND_BITS-1:0] K_NIL      = 6'd28;
    localparam logic [KIND_BITS-1:0] K_OR       = 6'd29;
    localparam logic [KIND_BITS-1:0] K_PRINT    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_RETURN   = 6'd31;
    localparam logic [KIND_BITS-1:0] K_TRUE     = 6'd32;
    localparam logic [KIND_BITS-1:0] K_VAR      = 6'd33;
    localparam logic [KIND_BITS-1:0] K_WHILE    = 6'd34;
    localparam logic [KIND_BITS-1:0] K_EOF      = 6'd35;
    localparam logic [KIND_BITS-1:0] K_ERR_CHAR = 6'd36;
    localparam logic [KIND_BITS-1:0] K_ERR_STR  = 6'd37;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // one token as it leaves the scanner core
    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic [LINE_BITS-1:0]   line;
    } token_t;

    // up to three tokens released by one item
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
        token_t     tok2;
    } burst_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // keyword lookup on the first six bytes and the length
    function automatic logic [KIND_BITS-1:0] ident_kind(input logic [47:0] p,
                                                      input logic [LENGTH_BITS-1:0] n);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        if (n == LENGTH_BITS'(3) && p[23:0] == 24'h646e61) k = K_AND;
        if (n == LENGTH_BITS'(4) && p[31:0] == 32'h65736c65) k = K_ELSE;
        if (n == LENGTH_BITS'(5) && p[39:0] == 40'h65736c6166) k = K_FALSE;
        if (n == LENGTH_BITS'(3) && p[23:0] == 24'h726f66) k = K_FOR;
        if (n == LENGTH_BITS'(3) && p[23:0] == 24'h6e7566) k = K_FUN;
        if (n == LENGTH_BITS'(2) && p[15:0] == 16'h6669) k = K_IF;
        if (n == LENGTH_BITS'(3) && p[23:0] == 24'h6c696e) k = K_NIL;
        if (n == LENGTH_BITS'(2) && p[15:0] == 16'h726f) k = K_OR;
        if (n == LENGTH_BITS'(5) && p[39:0] == 40'h746e697270) k = K_PRINT;
        if (n == LENGTH_BITS'(6) && p[47:0] == 48'h6e7275746572) k = K_RETURN;
        if (n == LENGTH_BITS'(4) && p[31:0] == 32'h65757274) k = K_TRUE;
        if (n == LENGTH_BITS'(3) && p[23:0] == 24'h726176) k = K_VAR;
        if (n == LENGTH_BITS'(5) && p[39:0] == 40'h656c696877) k = K_WHILE;
        return k;
    endfunction

endpackage

// File: hw/rtl/sts_core.sv
// ----------------------------------------------------------------------------
// sts_core
// scanner state and the single-pass next-state and token logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_core
    import sts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       op,
    input  logic [7:0] source_byte,
    output burst_t     burst
);

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] offs_reg, offs_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            start_reg  <= '0;
            offs_reg   <= '0;
            line_reg   <= LINE_BITS'(1);
            prefix_reg <= '0;
            len_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            offs_reg   <= offs_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
        end
    end

    logic [7:0]             c;
    logic                   at_end;
    logic [LENGTH_BITS-1:0] len_inc1, len_inc2;
    logic [LINE_BITS-1:0]   line_inc;
    logic [OFFSET_BITS-1:0] offs_inc;

    assign c        = source_byte;
    assign at_end   = (op == OP_END) || (c == 8'h00);
    assign len_inc1 = (&len_reg) ? len_reg : len_reg + LENGTH_BITS'(1);
    assign len_inc2 = (len_reg >= {LENGTH_BITS{1'b1}} - LENGTH_BITS'(1)) ?
                      {LENGTH_BITS{1'b1}} : len_reg + LENGTH_BITS'(2);
    assign line_inc = (&line_reg) ? line_reg : line_reg + LINE_BITS'(1);
    assign offs_inc = (&offs_reg) ? offs_reg : offs_reg + OFFSET_BITS'(1);

    logic [1:0]  cnt;
    token_t      t0, t1, t2;

    always_comb
    begin
        logic       do_flush;
        logic       do_idle;
        logic [LINE_BITS-1:0] ln;
        logic [1:0] n;
        token_t     tk [3];
        token_t     tmp;

        mode_next   = mode_reg;
        start_next  = start_reg;
        offs_next   = offs_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        do_flush    = 1'b0;
        do_idle     = 1'b0;
        ln          = line_reg;
        n           = 2'd0;
        tk[0]       = '0;
        tk[1]       = '0;
        tk[2]       = '0;
        tmp         = '0;

        if (mode_reg == M_DONE)
        begin
            tk[0] = '{K_EOF, offs_reg, '0, line_reg};
            n     = 2'd1;
        end
        else
        begin
            if (at_end)
                do_flush = 1'b1;
            else
            begin
                offs_next = offs_inc;
                if (mode_reg == M_SLASH && c == 8'h2f)
                    mode_next = M_COMMENT;
                else if (mode_reg == M_COMMENT)
                begin
                    if (c == 8'h0a)
                        do_idle = 1'b1;
                end
                else if ((mode_reg == M_BANG || mode_reg == M_EQUAL ||
                          mode_reg == M_LESS || mode_reg == M_GREATER) && c == 8'h3d)
                begin
                    tmp.kind   = (mode_reg == M_BANG)  ? K_BANG_EQ :
                                 (mode_reg == M_EQUAL) ? K_EQ_EQ :
                                 (mode_reg == M_LESS)  ? K_LT_EQ : K_GT_EQ;
                    tmp.start  = start_reg;
                    tmp.length = LENGTH_BITS'(2);
                    tmp.line   = line_reg;
                    tk[0]      = tmp;
                    n          = 2'd1;
                    mode_next  = M_IDLE;
                end
                else if (mode_reg == M_IDENT && (is_letter(c) || is_num_char(c)))
                begin
                    case (len_reg)
                        LENGTH_BITS'(1): prefix_next[15:8]  = c;
                        LENGTH_BITS'(2): prefix_next[23:16] = c;
                        LENGTH_BITS'(3): prefix_next[31:24] = c;
                        LENGTH_BITS'(4): prefix_next[39:32] = c;
                        LENGTH_BITS'(5): prefix_next[47:40] = c;
                        default: ;
                    endcase
                    len_next = len_inc1;
                end
                else if ((mode_reg == M_NUM || mode_reg == M_FRAC) && is_num_char(c))
                    len_next = len_inc1;
                else if (mode_reg == M_NUM && c == 8'h2e)
                begin
                    mode_next   = M_NUMDOT;
                    prefix_next = 48'(offs_reg);
                end
                else if (mode_reg == M_NUMDOT && is_num_char(c))
                begin
                    len_next  = len_inc2;
                    mode_next = M_FRAC;
                end
                else if (mode_reg == M_STRING)
                begin
                    len_next = len_inc1;
                    if (c == 8'h0a)
                    begin
                        line_next = line_inc;
                        ln        = line_inc;
                    end
                    if (c == 8'h22)
                    begin
                        tk[0]     = '{K_STRING, start_reg, len_inc1, ln};
                        n         = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                else
                begin
                    do_flush = 1'b1;
                    do_idle  = 1'b1;
                end
            end

            // pending token of the old mode
            if (do_flush)
            begin
                mode_next = M_IDLE;
                case (mode_reg)
                    M_SLASH:   begin tk[0] = '{K_SLASH, start_reg, LENGTH_BITS'(1), line_reg}; n = 2'd1; end
                    M_BANG:    begin tk[0] = '{K_BANG, start_reg, LENGTH_BITS'(1), line_reg}; n = 2'd1; end
                    M_EQUAL:   begin tk[0] = '{K_EQUAL, start_reg, LENGTH_BITS'(1), line_reg}; n = 2'd1; end
                    M_LESS:    begin tk[0] = '{K_LESS, start_reg, LENGTH_BITS'(1), line_reg}; n = 2'd1; end
                    M_GREATER: begin tk[0] = '{K_GREATER, start_reg, LENGTH_BITS'(1), line_reg}; n = 2'd1; end
                    M_IDENT:   begin tk[0] = '{ident_kind(prefix_reg, len_reg), start_reg, len_reg, line_reg}; n = 2'd1; end
                    M_NUM, M_FRAC:
                    begin
                        tk[0] = '{K_NUMBER, start_reg, len_reg, line_reg};
                        n     = 2'd1;
                    end
                    M_NUMDOT:
                    begin
                        tk[0] = '{K_NUMBER, start_reg, len_reg, line_reg};
                        tk[1] = '{K_DOT, prefix_reg[OFFSET_BITS-1:0], LENGTH_BITS'(1), line_reg};
                        n     = 2'd2;
                    end
                    M_STRING:  begin tk[0] = '{K_ERR_STR, start_reg, '0, line_reg}; n = 2'd1; end
                    default: ;
                endcase
            end

            if (at_end)
            begin
                tk[n]     = '{K_EOF, offs_reg, '0, line_reg};
                n         = n + 2'd1;
                mode_next = M_DONE;
            end
            else if (do_idle)
            begin
                // byte seen from the idle state
                mode_next = M_IDLE;
                tmp       = '{K_ERR_CHAR, offs_reg, '0, line_reg};
                if (c == 8'h20 || c == 8'h0d || c == 8'h09)
                    ;
                else if (c == 8'h0a)
                    line_next = line_inc;
                else if (is_letter(c))
                begin
                    mode_next   = M_IDENT;
                    start_next  = offs_reg;
                    len_next    = LENGTH_BITS'(1);
                    prefix_next = {40'd0, c};
                end
                else if (is_num_char(c))
                begin
                    mode_next  = M_NUM;
                    start_next = offs_reg;
                    len_next   = LENGTH_BITS'(1);
                end
                else
                begin
                    case (c)
                        8'h22: mode_next = M_STRING;
                        8'h2f: mode_next = M_SLASH;
                        8'h21: mode_next = M_BANG;
                        8'h3d: mode_next = M_EQUAL;
                        8'h3c: mode_next = M_LESS;
                        8'h3e: mode_next = M_GREATER;
                        default: ;
                    endcase
                    if (mode_next != M_IDLE)
                    begin
                        start_next = offs_reg;
                        len_next   = LENGTH_BITS'(1);
                    end
                    else
                    begin
                        tmp.length = LENGTH_BITS'(1);
                        case (c)
                            8'h28: tmp.kind = K_LPAREN;
                            8'h29: tmp.kind = K_RPAREN;
                            8'h7b: tmp.kind = K_LBRACE;
                            8'h7d: tmp.kind = K_RBRACE;
                            8'h2c: tmp.kind = K_COMMA;
                            8'h2e: tmp.kind = K_DOT;
                            8'h2d: tmp.kind = K_MINUS;
                            8'h2b: tmp.kind = K_PLUS;
                            8'h3b: tmp.kind = K_SEMI;
                            8'h2a: tmp.kind = K_STAR;
                            default: tmp.length = '0;
                        endcase
                        tk[n] = tmp;
                        n     = n + 2'd1;
                    end
                end
            end
        end

        cnt = n;
        t0  = tk[0];
        t1  = tk[1];
        t2  = tk[2];
    end

    assign burst = '{cnt, t0, t1, t2};

endmodule

// File: hw/rtl/script_token_scanner.sv
// ----------------------------------------------------------------------------
// script_token_scanner
// streaming lexer: one source byte per item in, zero to three tokens out
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | op, source_byte
//  out     | out_valid | out_stall | token_kind, token_start, token_length,
//          |           |           | token_line, last_of_run
//
// an item is taken in any cycle with no leftover tokens and a result register
// that is empty or being read; its first token, if any, shows in the next cycle.
// an item that releases two or three tokens holds the input while the
// leftovers drain, one token per cycle while out_stall is low.
// reset clears the scan state to idle, offsets to zero and the line to one.
// out_stall holds the result register and, while a result waits, the input.
`timescale 1ns / 1ps
`include "script_token_scanner_defines.svh"

module script_token_scanner
    import sts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [7:0]             source_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [KIND_BITS-1:0]   token_kind,
    output logic [OFFSET_BITS-1:0] token_start,
    output logic [LENGTH_BITS-1:0] token_length,
    output logic [LINE_BITS-1:0]   token_line,
    output logic                   last_of_run
);

    burst_t burst;
    logic   step;

    // result register and leftover tokens of the current burst
    logic       ovalid_reg, ovalid_next;
    token_t     otok_reg, otok_next;
    logic       olast_reg, olast_next;
    logic [1:0] left_reg, left_next;
    token_t     q1_reg, q1_next;
    token_t     q2_reg, q2_next;

    logic out_take;
    logic out_free;

    assign out_take = ovalid_reg && !out_stall;
    // the result register can load this cycle
    assign out_free = !ovalid_reg || !out_stall;
    // take input only when no leftovers remain and the output slot frees up
    assign in_stall = (left_reg != 2'd0) || !out_free;
    assign step     = in_valid && !in_stall;

    sts_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .op          (op),
        .source_byte (source_byte),
        .burst       (burst)
    );

    always_comb
    begin
        ovalid_next = ovalid_reg;
        otok_next   = otok_reg;
        olast_next  = olast_reg;
        left_next   = left_reg;
        q1_next     = q1_reg;
        q2_next     = q2_reg;
        if (out_take)
            ovalid_next = 1'b0;
        if (out_free)
        begin
            if (left_reg != 2'd0)
            begin
                // drain next leftover token
                ovalid_next = 1'b1;
                otok_next   = q1_reg;
                olast_next  = (left_reg == 2'd1);
                q1_next     = q2_reg;
                left_next   = left_reg - 2'd1;
            end
            else if (step && burst.count != 2'd0)
            begin
                ovalid_next = 1'b1;
                otok_next   = burst.tok0;
                olast_next  = (burst.count == 2'd1);
                q1_next     = burst.tok1;
                q2_next     = burst.tok2;
                left_next   = burst.count - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            left_reg   <= 2'd0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        otok_reg  <= otok_next;
        olast_reg <= olast_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
    end

    assign out_valid    = ovalid_reg;
    assign token_kind   = otok_reg.kind;
    assign token_start  = otok_reg.start;
    assign token_length = otok_reg.length;
    assign token_line   = otok_reg.line;
    assign last_of_run  = olast_reg;

    // leftovers mean the shown token is not the last of its burst
    `STS_ASSERT_IMPL(a_left_not_last, clk, rst_n, left_reg != 2'd0, ovalid_reg && !olast_reg, "leftover tokens behind a last token")
    // no input is taken while leftovers drain
    `STS_ASSERT_IMPL(a_no_step_left, clk, rst_n, left_reg != 2'd0, !step, "input taken during drain")
    // a stalled result stays put
    `STS_ASSERT_NEXT(a_hold, clk, rst_n, ovalid_reg && out_stall, ovalid_reg && $stable(otok_reg), "stalled result changed")

endmodule
